// File: sv/sre_pkg.sv
// Shared types and constants of the signed rank test engine.
`timescale 1ns / 1ps
package sre_pkg;
  localparam int MaxPairs = 256;
  localparam int SampleW = 16;
  localparam int MagW = 17;
  localparam int CntW = $clog2(MaxPairs + 1);
  localparam int RankW = CntW + 1;
  localparam int SgnCntW = CntW + 1;
  localparam int SumW = 19;
  localparam int DW = SumW - 1;
  localparam int ZW = 16;
  localparam int QW = 16;
  localparam int BitW = 4;
  localparam int AW = 27;
  localparam int KW = QW + 1;
  localparam int KKW = 2 * KW;
  localparam int PW = 27;
  localparam int SqW = 2 * AW;
  localparam int RhsW = SqW + 3;
  localparam int ProdW = KKW + PW;

  typedef struct packed {
    logic            valid;
    logic            neg;
    logic [MagW-1:0] mag;
  } entry_t;
endpackage

// File: sv/sre_cell.sv
// One cell of the sorted insertion chain holding a nonzero difference.
`timescale 1ns / 1ps
module sre_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            ins_en,
  input  logic            shift_en,
  input  sre_pkg::entry_t new_entry,
  input  sre_pkg::entry_t left_entry,
  input  logic            left_gt,
  input  sre_pkg::entry_t right_entry,
  output sre_pkg::entry_t entry,
  output logic            gt
);
  logic                     valid;
  logic                     neg;
  logic [sre_pkg::MagW-1:0] mag;

  assign entry = '{valid: valid, neg: neg, mag: mag};
  assign gt = valid && (mag > new_entry.mag);

  always_ff @(posedge clk) begin
    if (shift_en) begin
      neg <= right_entry.neg;
      mag <= right_entry.mag;
    end else if (ins_en) begin
      if (left_gt) begin
        neg <= left_entry.neg;
        mag <= left_entry.mag;
      end else if ((gt || !valid) && left_entry.valid) begin
        neg <= new_entry.neg;
        mag <= new_entry.mag;
      end
    end
  end

  // An empty cell fills either from the new value or from its shifted neighbor.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift_en) begin
      valid <= right_entry.valid;
    end else if (ins_en && !valid && left_entry.valid) begin
      valid <= 1'b1;
    end
  end
endmodule

// File: sv/sre_zscore.sv
// Sequential unit that computes the saturated Q5.10 normal approximation score.
`timescale 1ns / 1ps
module sre_zscore (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [sre_pkg::DW-1:0]      d,
  input  logic [sre_pkg::CntW-1:0]    n,
  output logic                        done,
  output logic signed [sre_pkg::ZW-1:0] z
);
  localparam logic [2:0] Z_IDLE = 3'd0;
  localparam logic [2:0] Z_INIT = 3'd1;
  localparam logic [2:0] Z_SQ   = 3'd2;
  localparam logic [2:0] Z_RHS  = 3'd3;
  localparam logic [2:0] Z_K    = 3'd4;
  localparam logic [2:0] Z_P    = 3'd5;
  localparam logic [2:0] Z_C    = 3'd6;

  logic [2:0]                  state;
  logic [sre_pkg::DW-1:0]      dr;
  logic [sre_pkg::CntW-1:0]    nr;
  logic                        dzero;
  logic [sre_pkg::AW-1:0]      a2;
  logic [2*sre_pkg::CntW:0]    nn1;
  logic [sre_pkg::CntW:0]      n2p1;
  logic [sre_pkg::SqW-1:0]     sq;
  logic [sre_pkg::PW-1:0]      p;
  logic [sre_pkg::RhsW-1:0]    rhs;
  logic [sre_pkg::QW-1:0]      q;
  logic [sre_pkg::QW-1:0]      cand;
  logic [sre_pkg::BitW-1:0]    bidx;
  logic [sre_pkg::KKW-1:0]     kk;
  logic [sre_pkg::ProdW-1:0]   prod;
  logic [sre_pkg::KW-1:0]      k;
  logic [sre_pkg::QW-1:0]      cand_now;
  logic [sre_pkg::QW-1:0]      q_fin;
  logic                        fits;

  assign cand_now = q | (sre_pkg::QW'(1) << bidx);
  assign k = {cand_now, 1'b0} - sre_pkg::KW'(1);
  assign fits = prod <= sre_pkg::ProdW'(rhs);
  assign q_fin = fits ? cand : q;

  always_ff @(posedge clk) begin
    case (state)
      Z_IDLE: begin
        dr <= d;
        nr <= n;
      end
      Z_INIT: begin
        dzero <= (dr == '0);
        a2 <= (dr == '0) ? sre_pkg::AW'(1024)
                         : sre_pkg::AW'({(dr - sre_pkg::DW'(1)), 10'b0});
        nn1 <= (2*sre_pkg::CntW+1)'(nr) * (2*sre_pkg::CntW+1)'({1'b0, nr} + 1'b1);
        n2p1 <= {nr, 1'b1};
      end
      Z_SQ: begin
        sq <= a2 * a2;
        p <= sre_pkg::PW'(sre_pkg::PW'(nn1) * sre_pkg::PW'(n2p1));
      end
      Z_RHS: begin
        rhs <= (sre_pkg::RhsW'(sq) << 2) + (sre_pkg::RhsW'(sq) << 1);
        q <= '0;
        bidx <= sre_pkg::BitW'(sre_pkg::QW - 1);
      end
      Z_K: begin
        cand <= cand_now;
        kk <= sre_pkg::KKW'(k) * sre_pkg::KKW'(k);
      end
      Z_P: begin
        prod <= sre_pkg::ProdW'(kk) * sre_pkg::ProdW'(p);
      end
      Z_C: begin
        q <= q_fin;
        bidx <= bidx - 1'b1;
        if (bidx == '0) begin
          if (dzero) begin
            z <= q_fin[sre_pkg::QW-1] ? {1'b1, {(sre_pkg::ZW-1){1'b0}}}
                                      : -$signed(q_fin);
          end else begin
            z <= q_fin[sre_pkg::QW-1] ? {1'b0, {(sre_pkg::ZW-1){1'b1}}}
                                      : $signed(q_fin);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= Z_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        Z_IDLE: if (start) state <= Z_INIT;
        Z_INIT: state <= Z_SQ;
        Z_SQ:   state <= Z_RHS;
        Z_RHS:  state <= Z_K;
        Z_K:    state <= Z_P;
        Z_P:    state <= Z_C;
        Z_C: begin
          if (bidx == '0) begin
            state <= Z_IDLE;
            done <= 1'b1;
          end else begin
            state <= Z_K;
          end
        end
        default: state <= Z_IDLE;
      endcase
    end
  end
endmodule

// File: sv/signed_rank_test_engine.sv
// Top level of the signed rank test engine: sorted cell chain, rank scan and result port.
`timescale 1ns / 1ps
// Pairs enter at one beat per cycle while the engine is loading. Each nonzero
// difference is inserted in sorted order into a chain of 256 cells, one per
// stored difference, as its pair is accepted. The beat flagged as the last
// pair closes the set: the chain then shifts its contents out through the rank
// scanner, one cell per cycle, and, for a nonempty set, the score unit is
// started, runs its setup states Z_INIT, Z_SQ and Z_RHS, then a 16-step bit
// search through the states Z_K, Z_P and Z_C per step, and hands back the score.
// The result is then placed in the output register. Input stalls from the last
// pair until then, and longer while the previous result still waits in the
// output register. The result register holds its beat until taken while the
// next set already loads. Pairs beyond the 256th of a set are dropped, but a
// last-pair flag on them still closes it.
module signed_rank_test_engine (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [sre_pkg::SampleW-1:0]  first_sample,
  input  logic signed [sre_pkg::SampleW-1:0]  second_sample,
  input  logic                                last_pair,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [sre_pkg::MagW-1:0]            rank_sum_doubled,
  output logic [sre_pkg::CntW-1:0]            nonzero_count,
  output logic signed [sre_pkg::ZW-1:0]       z_score,
  output logic                                empty_set
);
  localparam logic [1:0] S_LOAD = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_ZWAIT = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  localparam sre_pkg::entry_t HeadEntry = '{valid: 1'b1, neg: 1'b0, mag: '0};
  localparam sre_pkg::entry_t EmptyEntry = '{valid: 1'b0, neg: 1'b0, mag: '0};

  logic [1:0]                        state;
  logic [sre_pkg::CntW-1:0]          pair_count;
  logic                              accept;
  logic                              ins_en;
  logic                              shift_en;
  logic signed [sre_pkg::MagW-1:0]   diff;
  sre_pkg::entry_t                   new_entry;
  sre_pkg::entry_t                   ent [sre_pkg::MaxPairs];
  logic                              gt [sre_pkg::MaxPairs];

  // Rank scan state: one tie group is open at a time.
  logic                              gact;
  logic [sre_pkg::MagW-1:0]          gval;
  logic [sre_pkg::CntW-1:0]          lcnt;
  logic [sre_pkg::CntW-1:0]          tcnt;
  logic signed [sre_pkg::SgnCntW-1:0] ccnt;
  logic signed [sre_pkg::SumW-1:0]   sum;
  logic [sre_pkg::RankW-1:0]         rank2;
  logic signed [2*sre_pkg::RankW-1:0] contrib;
  logic                              close_grp;
  logic                              same_grp;
  logic signed [sre_pkg::SumW-1:0]   sum_next;
  logic [sre_pkg::CntW-1:0]          lcnt_next;
  logic [sre_pkg::DW-1:0]            dabs;
  logic                              z_start;
  logic                              z_done;
  logic signed [sre_pkg::ZW-1:0]     z_val;
  logic [sre_pkg::MagW-1:0]          res_sum;
  logic [sre_pkg::CntW-1:0]          res_n;
  logic signed [sre_pkg::ZW-1:0]     res_z;
  logic                              res_empty;
  logic                              sgn_one;
  logic                              z_busy_seen;

  assign in_stall = (state != S_LOAD);
  assign accept = in_valid && !in_stall;
  assign diff = sre_pkg::MagW'(first_sample) - sre_pkg::MagW'(second_sample);
  assign new_entry = '{valid: 1'b1, neg: diff[sre_pkg::MagW-1],
                       mag: diff[sre_pkg::MagW-1] ? -diff : diff};
  assign ins_en = accept && (pair_count < sre_pkg::CntW'(sre_pkg::MaxPairs))
                  && (diff != '0);
  assign shift_en = (state == S_SCAN);

  // The chain keeps its valid entries as an ascending prefix.
  for (genvar i = 0; i < sre_pkg::MaxPairs; i++) begin : g_cell
    sre_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ins_en     (ins_en),
      .shift_en   (shift_en),
      .new_entry  (new_entry),
      .left_entry ((i == 0) ? HeadEntry : ent[(i == 0) ? 0 : i-1]),
      .left_gt    ((i == 0) ? 1'b0 : gt[(i == 0) ? 0 : i-1]),
      .right_entry((i == sre_pkg::MaxPairs-1) ? EmptyEntry
                   : ent[(i == sre_pkg::MaxPairs-1) ? i : i+1]),
      .entry      (ent[i]),
      .gt         (gt[i])
    );
  end

  // A tie group of t members after L smaller values carries doubled rank 2L+t+1,
  // weighted by its count of positive minus negative members.
  assign same_grp = gact && ent[0].valid && (ent[0].mag == gval);
  assign close_grp = gact && !same_grp;
  assign rank2 = sre_pkg::RankW'({lcnt, 1'b0}) + sre_pkg::RankW'(tcnt) + 1'b1;
  assign contrib = ccnt * $signed({1'b0, rank2});
  assign sum_next = close_grp ? sum + sre_pkg::SumW'(contrib) : sum;
  assign lcnt_next = close_grp ? lcnt + tcnt : lcnt;
  assign dabs = sum[sre_pkg::SumW-1] ? sre_pkg::DW'(-sum) : sre_pkg::DW'(sum);
  assign sgn_one = ent[0].neg;
  assign z_start = (state == S_SCAN) && !ent[0].valid && (lcnt_next != '0);

  sre_zscore u_zscore (
    .clk  (clk),
    .rst  (rst),
    .start(state == S_ZWAIT && !z_busy_seen),
    .d    (dabs),
    .n    (lcnt),
    .done (z_done),
    .z    (z_val)
  );

  always_ff @(posedge clk) begin
    if (state == S_LOAD) begin
      gact <= 1'b0;
      lcnt <= '0;
      sum <= '0;
    end else if (state == S_SCAN) begin
      sum <= sum_next;
      lcnt <= lcnt_next;
      if (ent[0].valid) begin
        if (same_grp) begin
          tcnt <= tcnt + 1'b1;
          ccnt <= sgn_one ? ccnt - 1'b1 : ccnt + 1'b1;
        end else begin
          gact <= 1'b1;
          gval <= ent[0].mag;
          tcnt <= sre_pkg::CntW'(1);
          ccnt <= sgn_one ? -sre_pkg::SgnCntW'(1) : sre_pkg::SgnCntW'(1);
        end
      end else begin
        gact <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_SCAN && !ent[0].valid) begin
      res_n <= lcnt_next;
      res_empty <= (lcnt_next == '0);
      res_z <= '0;
    end
    if (state == S_ZWAIT) begin
      res_sum <= dabs[sre_pkg::MagW-1:0];
      if (z_done) res_z <= z_val;
    end
    if (state == S_SCAN && !ent[0].valid && lcnt_next == '0) begin
      res_sum <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      pair_count <= '0;
      out_valid <= 1'b0;
      z_busy_seen <= 1'b0;
    end else begin
      // The output register refills in the same cycle that its beat is taken.
      if (state == S_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (accept) begin
            if (last_pair) begin
              pair_count <= '0;
              state <= S_SCAN;
            end else if (pair_count < sre_pkg::CntW'(sre_pkg::MaxPairs)) begin
              pair_count <= pair_count + 1'b1;
            end
          end
        end
        S_SCAN: begin
          if (!ent[0].valid) begin
            state <= z_start ? S_ZWAIT : S_DONE;
            z_busy_seen <= 1'b0;
          end
        end
        S_ZWAIT: begin
          z_busy_seen <= 1'b1;
          if (z_done) state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            rank_sum_doubled <= res_sum;
            nonzero_count <= res_n;
            z_score <= res_z;
            empty_set <= res_empty;
            state <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end
endmodule

// File: dv/signed_rank_test_engine_tb.sv
// Self-checking testbench of the signed rank test engine: directed table, random sets, scoreboard.
`timescale 1ns / 1ps
module signed_rank_test_engine_tb;

  // One result beat of the engine.
  typedef struct {
    logic [sre_pkg::MagW-1:0]     rank_sum;
    logic [sre_pkg::CntW-1:0]     count;
    logic signed [sre_pkg::ZW-1:0] z;
    logic                         empty;
  } score_t;

  // One row of the directed table. Rows with has_score set carry an expected
  // result that is obvious from the rules; all other rows use the predictor.
  typedef struct {
    logic signed [sre_pkg::SampleW-1:0] a;
    logic signed [sre_pkg::SampleW-1:0] b;
    logic                               last;
    logic                               has_score;
    score_t                             score;
  } pair_row_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic signed [sre_pkg::SampleW-1:0] first_sample;
  logic signed [sre_pkg::SampleW-1:0] second_sample;
  logic last_pair;
  logic out_valid;
  logic out_stall;
  logic [sre_pkg::MagW-1:0] rank_sum_doubled;
  logic [sre_pkg::CntW-1:0] nonzero_count;
  logic signed [sre_pkg::ZW-1:0] z_score;
  logic empty_set;

  signed_rank_test_engine dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .first_sample(first_sample), .second_sample(second_sample), .last_pair(last_pair),
    .out_valid(out_valid), .out_stall(out_stall),
    .rank_sum_doubled(rank_sum_doubled), .nonzero_count(nonzero_count),
    .z_score(z_score), .empty_set(empty_set)
  );

  // Predictor state: the magnitudes and signs of the pairs stored in the open set.
  logic [sre_pkg::MagW-1:0] set_mags[$];
  logic                     set_negs[$];
  score_t                   pending_scores[$];
  int                       mismatches = 0;
  bit                       tx_gaps = 1'b1;
  bit                       rx_gaps = 1'b1;
  bit                       hold_request = 1'b0;
  int                       quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Largest q in [0, 32768] with (2q - 1)^2 * v <= (2a)^2, which is
  // a / sqrt(v) rounded to nearest with halves upward.
  function automatic longint unsigned root_quotient(longint unsigned a, longint unsigned v);
    longint unsigned lo, hi, mid, k, rhs;
    lo = 0;
    hi = 32768;
    rhs = (2 * a) * (2 * a);
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      k = 2 * mid - 1;
      if (k * k * v <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  // Ranks the stored set with tied groups on their averaged (doubled) rank,
  // then forms the doubled absolute rank sum and the saturated Q5.10 score.
  function automatic score_t close_set();
    score_t s;
    longint sum, r;
    longint unsigned d, v, q, n;
    int smaller, equal;
    sum = 0;
    n = 0;
    foreach (set_mags[i]) begin
      if (set_mags[i] != 0) begin
        n++;
        smaller = 0;
        equal = 0;
        foreach (set_mags[j]) begin
          if (set_mags[j] != 0 && set_mags[j] < set_mags[i]) smaller++;
          else if (set_mags[j] == set_mags[i]) equal++;
        end
        r = 2 * smaller + equal + 1;
        sum += set_negs[i] ? -r : r;
      end
    end
    d = (sum < 0) ? -sum : sum;
    s.z = '0;
    if (n > 0) begin
      v = n * (n + 1) * (2 * n + 1) / 6;
      if (d == 0) begin
        // A perfectly balanced set gives a score of zero or below.
        q = root_quotient(512, v);
        s.z = (q > 32768) ? -16'sd32768 : sre_pkg::ZW'(-$signed(q));
      end else begin
        q = root_quotient((d - 1) * 512, v);
        s.z = (q > 32767) ? 16'sd32767 : sre_pkg::ZW'(q);
      end
    end
    s.rank_sum = d[sre_pkg::MagW-1:0];
    s.count = n[sre_pkg::CntW-1:0];
    s.empty = (n == 0);
    set_mags.delete();
    set_negs.delete();
    return s;
  endfunction

  // Offers one pair, after a random gap when tx_gaps is set, and waits for the engine to take it.
  // The prediction is updated at acceptance so expectations keep input order.
  task automatic send_pair(input logic signed [sre_pkg::SampleW-1:0] a,
                           input logic signed [sre_pkg::SampleW-1:0] b,
                           input logic last, input logic has_score,
                           input score_t typed);
    int gap;
    int diff;
    score_t s;
    gap = tx_gaps ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    first_sample <= a;
    second_sample <= b;
    last_pair <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (set_mags.size() < sre_pkg::MaxPairs) begin
      diff = int'(a) - int'(b);
      set_mags.push_back(sre_pkg::MagW'((diff < 0) ? -diff : diff));
      set_negs.push_back(diff < 0);
    end
    if (last) begin
      s = close_set();
      pending_scores.push_back(has_score ? typed : s);
    end
  endtask

  function automatic logic signed [sre_pkg::SampleW-1:0] pick_sample(int style);
    case (style)
      0: return 16'($urandom());
      1: return $signed(16'($urandom_range(0, 6))) - 16'sd3;
      default: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    endcase
  endfunction

  // Sends one random set of the given length. Pairs are full range or, with a share
  // set by tie_weight, come from a tiny pool so ties and zero differences are common.
  task automatic send_random_set(input int len, input int tie_weight);
    logic signed [sre_pkg::SampleW-1:0] a, b;
    int style;
    score_t none;
    none = '{default: '0};
    for (int i = 0; i < len; i++) begin
      style = ($urandom_range(0, 99) < tie_weight) ? 1 : ($urandom_range(0, 19) == 0 ? 2 : 0);
      a = pick_sample(style);
      b = ($urandom_range(0, 15) == 0) ? a : pick_sample(style);
      send_pair(a, b, i == len - 1, 1'b0, none);
    end
  endtask

  // Receiver: random stall before each beat, an occasional long hold-off.
  initial begin
    int k;
    out_stall = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (700) @(posedge clk);
      end else begin
        k = rx_gaps ? $urandom_range(0, 15) : 0;
        if (k > 0) begin
          out_stall <= 1'b1;
          repeat (k) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Scoreboard on the result port and the no-progress watchdog.
  always @(posedge clk) begin
    score_t e;
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
        $display("simulation failed");
        $finish;
      end
    end
    if (!rst && out_valid && !out_stall) begin
      if (pending_scores.size() == 0) begin
        $error("result beat with nothing expected");
        mismatches++;
      end else begin
        e = pending_scores.pop_front();
        if (rank_sum_doubled !== e.rank_sum) begin
          $error("rank_sum_doubled: expected %0d, got %0d", e.rank_sum, rank_sum_doubled);
          mismatches++;
        end
        if (nonzero_count !== e.count) begin
          $error("nonzero_count: expected %0d, got %0d", e.count, nonzero_count);
          mismatches++;
        end
        if (z_score !== e.z) begin
          $error("z_score: expected %0d, got %0d", e.z, z_score);
          mismatches++;
        end
        if (empty_set !== e.empty) begin
          $error("empty_set: expected %0d, got %0d", e.empty, empty_set);
          mismatches++;
        end
      end
    end
  end

  // Directed rows: empty set, both extreme differences, balanced ties,
  // a triple tie, a mixed set and a single large difference.
  pair_row_t directed[] = '{
    '{16'sd0, 16'sd0, 1'b1, 1'b1, '{17'd0, 9'd0, 16'sd0, 1'b1}},
    '{16'sd5, 16'sd5, 1'b0, 1'b0, '{default: '0}},
    '{-16'sd9, -16'sd9, 1'b1, 1'b1, '{17'd0, 9'd0, 16'sd0, 1'b1}},
    '{16'sh7fff, 16'sh8000, 1'b1, 1'b1, '{17'd2, 9'd1, 16'sd512, 1'b0}},
    '{16'sh8000, 16'sh7fff, 1'b1, 1'b1, '{17'd2, 9'd1, 16'sd512, 1'b0}},
    '{16'sd10, 16'sd5, 1'b0, 1'b0, '{default: '0}},
    '{16'sd0, 16'sd5, 1'b1, 1'b0, '{default: '0}},
    '{16'sd3, 16'sd0, 1'b0, 1'b0, '{default: '0}},
    '{16'sd0, 16'sd3, 1'b0, 1'b0, '{default: '0}},
    '{16'sd7, 16'sd4, 1'b0, 1'b0, '{default: '0}},
    '{16'sd1, 16'sd1, 1'b1, 1'b0, '{default: '0}},
    '{16'sh7fff, 16'sd0, 1'b0, 1'b0, '{default: '0}},
    '{16'sh8000, 16'sd0, 1'b0, 1'b0, '{default: '0}},
    '{16'sd1, 16'sd0, 1'b0, 1'b0, '{default: '0}},
    '{-16'sd1, 16'sd0, 1'b0, 1'b0, '{default: '0}},
    '{16'sd2, 16'sd0, 1'b1, 1'b0, '{default: '0}},
    '{16'sh5555, 16'shaaaa, 1'b1, 1'b0, '{default: '0}}
  };

  initial begin
    score_t none;
    int items;
    none = '{default: '0};
    rst = 1'b1;
    in_valid = 1'b0;
    first_sample = '0;
    second_sample = '0;
    last_pair = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i])
      send_pair(directed[i].a, directed[i].b, directed[i].last,
                directed[i].has_score, directed[i].score);

    // A full set past the capacity: the extra pairs are dropped but the
    // flagged one still closes the set.
    send_random_set(sre_pkg::MaxPairs + 4, 30);

    // The sender keeps offering while the receiver holds off, so the result
    // register fills and the engine has to stall its input.
    hold_request = 1'b1;
    for (int s = 0; s < 6; s++) send_random_set($urandom_range(1, 4), 40);

    // Pause until the engine has drained every expected beat.
    in_valid <= 1'b0;
    wait (pending_scores.size() == 0);
    @(posedge clk);

    items = 0;
    while (items < 1000) begin
      int len;
      tx_gaps = ($urandom_range(0, 3) != 0);
      rx_gaps = ($urandom_range(0, 3) != 0);
      len = ($urandom_range(0, 99) == 0)
            ? $urandom_range(sre_pkg::MaxPairs - 2, sre_pkg::MaxPairs + 3)
            : $urandom_range(1, 24);
      send_random_set(len, $urandom_range(0, 80));
      items += len;
    end
    in_valid <= 1'b0;

    wait (pending_scores.size() == 0);
    repeat (400) @(posedge clk);
    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
